@@ rtl/rgb_to_hsl_converter_unit_defines.svh @@
// Assertion macros for the checker file of the colour converter.
// Depends on nothing; expects clk_i and rst_ni in the scope of each use.
`ifndef RGB_TO_HSL_CONVERTER_UNIT_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, held off in reset.
`define RHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, held off in reset.
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rhc_pkg.sv @@
// Shared widths, the divider lane type and its step functions for the
// colour converter. Depends on nothing.
package rhc_pkg;

  localparam int FRACTION_BITS   = 16;
  localparam int PIX_W           = 8;
  localparam int OUT_W           = 16;
  localparam int SUM_W           = PIX_W + 1;   // max + min
  localparam int DIV_W           = PIX_W + 3;   // holds six times the range
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES      = (FRACTION_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  localparam int LANES      = 3;
  localparam int LANE_HUE   = 0;
  localparam int LANE_SAT   = 1;
  localparam int LANE_LIGHT = 2;

  localparam logic [SUM_W-1:0]         PIX_MAX       = SUM_W'((1 << PIX_W) - 1);
  localparam logic [SUM_W-1:0]         LIGHT_DIVISOR = SUM_W'(2 * ((1 << PIX_W) - 1));
  localparam logic [FRACTION_BITS-1:0] FULL_SCALE    = {FRACTION_BITS{1'b1}};

  // Partial remainder, divisor, and a word that shifts out dividend bits
  // while quotient bits shift in.
  typedef struct packed {
    logic [DIV_W-1:0]         rem;
    logic [DIV_W-1:0]         dvs;
    logic [FRACTION_BITS-1:0] acc;
  } div_lane_t;

  function automatic div_lane_t div_step(input div_lane_t l);
    logic [DIV_W:0] trial;
    logic           q_bit;
    div_lane_t      r;
    r     = l;
    trial = {l.rem, l.acc[FRACTION_BITS-1]};
    q_bit = (trial >= {1'b0, l.dvs});
    if (q_bit) begin
      r.rem = DIV_W'(trial - {1'b0, l.dvs});
    end else begin
      r.rem = trial[DIV_W-1:0];
    end
    r.acc = {l.acc[FRACTION_BITS-2:0], q_bit};
    return r;
  endfunction

  // One pipeline stage of the divider: a handful of steps, skipping any
  // beyond the fraction width in the final stage.
  function automatic div_lane_t div_stage(input div_lane_t l, input int stage);
    div_lane_t r;
    r = l;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      if (stage * STEPS_PER_STAGE + k < FRACTION_BITS) begin
        r = div_step(r);
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/rgb_to_hsl_converter_unit.sv @@
// Top level of the RGB to HSL colour converter: pipeline and handshake.
// Depends on rhc_pkg.
//
// Usage
//   Input channel: red_i, green_i, blue_i with valid_i; this block drives
//   stall_o; a word is taken on a rising edge with valid_i high and stall_o low.
//   Output channel: hue_o, saturation_o, lightness_o with valid_o; the
//   receiver drives stall_i; a word leaves on an edge with valid_o high and
//   stall_i low.
//   A word passes seven register stages on its way to valid_o: one stage
//   finds the largest and smallest component, one forms sum, range and the
//   hue sector numerator, one sets up three divider lanes, and four run the
//   16-step restoring dividers at four steps each. Throughput is one pixel
//   per cycle while the receiver does not stall.
//   Each stage has its own valid bit and moves when the stage after it
//   can take its word, so bubbles close up and a stalled output word holds
//   while the earlier stages keep filling; stall_o rises only when every
//   stage holds a word and the receiver stalls.
//   Reset clears every valid bit; the block is ready in the first cycle
//   after reset is released.
module rgb_to_hsl_converter_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  logic [rhc_pkg::PIX_W-1:0]   red_i,
  input  logic [rhc_pkg::PIX_W-1:0]   green_i,
  input  logic [rhc_pkg::PIX_W-1:0]   blue_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output logic [rhc_pkg::OUT_W-1:0]   hue_o,
  output logic [rhc_pkg::OUT_W-1:0]   saturation_o,
  output logic [rhc_pkg::OUT_W-1:0]   lightness_o
);
  import rhc_pkg::*;

  localparam int LANE_BASE = 2;                       // stage of the lane set-up
  localparam int TOTAL     = LANE_BASE + 1 + DIV_STAGES;

  // Handshake: a valid bit per stage, load enables rippling back.
  logic [TOTAL-1:0] v_q;
  logic [TOTAL-1:0] v_in;
  logic [TOTAL:0]   en;

  always_comb begin
    en[TOTAL] = !stall_i;
    for (int k = TOTAL - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_in    = {v_q[TOTAL-2:0], valid_i};
  assign stall_o = !en[0];
  assign valid_o = v_q[TOTAL-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < TOTAL; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // Stage 0: hold the components and pick the extremes.
  logic [PIX_W-1:0] r0_q, g0_q, b0_q, mx0_q, mn0_q;
  logic [PIX_W-1:0] mx0_d, mn0_d;

  always_comb begin
    mx0_d = red_i;
    mn0_d = red_i;
    if (green_i > mx0_d) mx0_d = green_i;
    if (blue_i > mx0_d)  mx0_d = blue_i;
    if (green_i < mn0_d) mn0_d = green_i;
    if (blue_i < mn0_d)  mn0_d = blue_i;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      r0_q  <= red_i;
      g0_q  <= green_i;
      b0_q  <= blue_i;
      mx0_q <= mx0_d;
      mn0_q <= mn0_d;
    end
  end

  // Stage 1: sum, range and the hue numerator of the max sector.
  logic [SUM_W-1:0]  sum1_q, sum1_d;
  logic [PIX_W-1:0]  rng1_q, rng1_d;
  logic [DIV_W-1:0]  num1_q, num1_d;
  logic signed [DIV_W:0] r_s, g_s, b_s, rng_s, num_s;

  always_comb begin
    sum1_d = SUM_W'(mx0_q) + SUM_W'(mn0_q);
    rng1_d = mx0_q - mn0_q;
    r_s    = $signed((DIV_W+1)'(r0_q));
    g_s    = $signed((DIV_W+1)'(g0_q));
    b_s    = $signed((DIV_W+1)'(b0_q));
    rng_s  = $signed((DIV_W+1)'(rng1_d));
    if (r0_q > g0_q && r0_q > b0_q) begin
      // red sector wraps round by a full turn when green is below blue
      num_s = g_s - b_s;
      if (g0_q < b0_q) num_s = num_s + (rng_s <<< 2) + (rng_s <<< 1);
    end else if (g0_q > b0_q) begin
      num_s = b_s - r_s + (rng_s <<< 1);
    end else begin
      num_s = r_s - g_s + (rng_s <<< 2);
    end
    num1_d = num_s[DIV_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sum1_q <= sum1_d;
      rng1_q <= rng1_d;
      num1_q <= num1_d;
    end
  end

  // Stage 2: load the three divider lanes. A dividend N below D * 2^F
  // splits into a starting remainder N >> F and F bits to shift in.
  div_lane_t lane_q [DIV_STAGES+1][LANES];
  div_lane_t lane_d [DIV_STAGES+1][LANES];
  logic [SUM_W-1:0]         sat_den;
  logic [PIX_W+FRACTION_BITS-1:0] sat_prod;
  logic [SUM_W+FRACTION_BITS-1:0] light_prod;

  always_comb begin
    sat_den    = (sum1_q > PIX_MAX) ? (LIGHT_DIVISOR - sum1_q) : sum1_q;
    sat_prod   = (PIX_W+FRACTION_BITS)'(rng1_q) * (PIX_W+FRACTION_BITS)'(FULL_SCALE);
    light_prod = (SUM_W+FRACTION_BITS)'(sum1_q) * (SUM_W+FRACTION_BITS)'(FULL_SCALE);

    lane_d[0][LANE_HUE].rem = num1_q;
    lane_d[0][LANE_HUE].dvs = DIV_W'({rng1_q, 2'b00}) + DIV_W'({rng1_q, 1'b0});
    lane_d[0][LANE_HUE].acc = '0;

    lane_d[0][LANE_SAT].rem = DIV_W'(sat_prod[PIX_W+FRACTION_BITS-1:FRACTION_BITS]);
    lane_d[0][LANE_SAT].dvs = DIV_W'(sat_den);
    lane_d[0][LANE_SAT].acc = sat_prod[FRACTION_BITS-1:0];

    // grey pixel: divide zero by one so hue and saturation come out zero
    if (rng1_q == '0) begin
      lane_d[0][LANE_HUE] = '{rem: '0, dvs: DIV_W'(1), acc: '0};
      lane_d[0][LANE_SAT] = '{rem: '0, dvs: DIV_W'(1), acc: '0};
    end

    lane_d[0][LANE_LIGHT].rem = DIV_W'(light_prod[SUM_W+FRACTION_BITS-1:FRACTION_BITS]);
    lane_d[0][LANE_LIGHT].dvs = DIV_W'(LIGHT_DIVISOR);
    lane_d[0][LANE_LIGHT].acc = light_prod[FRACTION_BITS-1:0];
  end

  // Stages 3 onward: advance each lane a few division steps per stage.
  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        lane_d[j][l] = div_stage(lane_q[j-1][l], j - 1);
      end
    end
  end

  for (genvar j = 0; j <= DIV_STAGES; j++) begin : g_lane_reg
    always_ff @(posedge clk_i) begin
      if (en[LANE_BASE+j]) begin
        lane_q[j] <= lane_d[j];
      end
    end
  end

  // The quotients have replaced the dividend bits; fit them to the fields.
  assign hue_o        = OUT_W'(lane_q[DIV_STAGES][LANE_HUE].acc);
  assign saturation_o = OUT_W'(lane_q[DIV_STAGES][LANE_SAT].acc);
  assign lightness_o  = OUT_W'(lane_q[DIV_STAGES][LANE_LIGHT].acc);

endmodule

@@ rtl/rhc_checker.sv @@
// Port-level checks for the colour converter, bound to its top level.
// Depends on rhc_pkg and rgb_to_hsl_converter_unit_defines.svh.
`include "rgb_to_hsl_converter_unit_defines.svh"

module rhc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      stall_o,
  input logic                      valid_o,
  input logic                      stall_i,
  input logic [rhc_pkg::OUT_W-1:0] hue_o,
  input logic [rhc_pkg::OUT_W-1:0] saturation_o,
  input logic [rhc_pkg::OUT_W-1:0] lightness_o
);
  import rhc_pkg::*;

  logic [3*OUT_W-1:0] out_word;
  assign out_word = {hue_o, saturation_o, lightness_o};

  // hold a stalled word
  `RHC_ASSERT_NEXT(a_out_valid_held, valid_o && stall_i, valid_o, "output word dropped under stall")
  `RHC_ASSERT_NEXT(a_out_word_held, valid_o && stall_i, $stable(out_word), "stalled output word changed")
  // back-pressure only ever comes from a stalled output word
  `RHC_ASSERT_NOW(a_stall_cause, stall_o, valid_o && stall_i, "input stalled with output free")
  // zero saturation only for grey pixels, which carry zero hue
  `RHC_ASSERT_NOW(a_grey_hue, valid_o && saturation_o == '0, hue_o == '0, "grey pixel with hue")

endmodule

bind rgb_to_hsl_converter_unit rhc_checker u_rhc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .stall_o      (stall_o),
  .valid_o      (valid_o),
  .stall_i      (stall_i),
  .hue_o        (hue_o),
  .saturation_o (saturation_o),
  .lightness_o  (lightness_o)
);
